// ===== hdl/brb_pkg.sv =====
// byte ring buffer burst read: shared beat types, command codes and register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_MIN_AVAIL   = 1'b0;
  localparam logic REG_BURST_LIMIT = 1'b1;

  localparam logic [7:0] MIN_AVAIL_RST   = 8'd3;
  localparam logic [4:0] BURST_LIMIT_RST = 5'd30;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] start_position;
  } brb_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [8:0] dest_index;
    logic       no_data;
    logic       last;
  } brb_out_t;

endpackage

`default_nettype wire

// ===== hdl/byte_ring_buffer_burst_read_core.sv =====
// Byte ring buffer with burst read. A write or clear beat is taken while idle and gives
// no result. A read beat that finds n bytes available (after the minimum threshold and
// the burst clamp) holds off the input until all n bytes are fetched, longer while
// downstream stalls and the output queue is full; the memory read port fetches one byte
// per cycle while the queue has room, and bytes leave at one per cycle when downstream
// does not stall, through a two-entry output queue. A read that finds nothing holds off
// the input until the queue has room, and gives a single no-data beat. The store is one
// synchronous RAM of BUFFER_DEPTH bytes; its single read port sets the burst rate.
// depends on brb_pkg, brb_ram, brb_out_fifo
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_burst_read_core
  import brb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 256,
  parameter int MAX_BURST    = 30
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire brb_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output brb_out_t        out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int AVW   = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;
  localparam int BW    = $clog2(MAX_BURST + 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(BUFFER_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [AVW-1:0]   MAX_EXT   = AVW'(MAX_BURST);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_EMPTY
  } state_e;

  state_e         state_q, state_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]     min_avail_q, min_avail_d;
  logic [4:0]     burst_lim_q, burst_lim_d;
  logic [7:0]     start_q, start_d;
  logic [BW-1:0]  rem_q, rem_d;
  logic [BW-1:0]  offs_q, offs_d;
  logic           inflight_q, inflight_d;
  logic [8:0]     meta_dest_q, meta_dest_d;
  logic           meta_last_q, meta_last_d;

  logic           accept;
  logic           pop;
  logic           space;
  logic           issue;
  logic [2:0]     occupancy;
  logic [PTR_W:0] ptr_dist;
  logic [AVW-1:0] avail;
  logic [AVW-1:0] limit;
  logic [AVW-1:0] count_ext;
  logic [BW-1:0]  count;
  logic [7:0]     ram_rdata;
  logic           fifo_push;
  brb_out_t       fifo_push_data;
  logic [1:0]     fifo_count;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign pop        = out_valid_o & ~out_stall_i;
  assign occupancy  = {1'b0, fifo_count} + {2'b0, inflight_q} - {2'b0, pop};
  assign space      = (occupancy < 3'd2);
  assign issue      = (state_q == ST_BURST) & space;

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      ptr_dist = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      ptr_dist = DEPTH_EXT - {1'b0, rd_ptr_q} + {1'b0, wr_ptr_q};
    end
    avail = AVW'(ptr_dist);
    if (avail < AVW'(min_avail_q)) begin
      avail = '0;
    end
    limit = (AVW'(burst_lim_q) > MAX_EXT) ? MAX_EXT : AVW'(burst_lim_q);
    count_ext = (avail > limit) ? limit : avail;
    count = count_ext[BW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    min_avail_d = min_avail_q;
    burst_lim_d = burst_lim_q;
    start_d     = start_q;
    rem_d       = rem_q;
    offs_d      = offs_q;
    inflight_d  = issue;
    meta_dest_d = meta_dest_q;
    meta_last_d = meta_last_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_AVAIL:   min_avail_d = cfg_wdata_i;
        REG_BURST_LIMIT: burst_lim_d = cfg_wdata_i[4:0];
        default:         ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.command)
            CMD_WRITE: begin
              wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
            end
            CMD_CLEAR: begin
              wr_ptr_d = '0;
              rd_ptr_d = '0;
            end
            CMD_READ: begin
              start_d = in_data_i.start_position;
              rem_d   = count;
              offs_d  = '0;
              state_d = (count == '0) ? ST_EMPTY : ST_BURST;
            end
            default: ;
          endcase
        end
      end
      ST_BURST: begin
        if (issue) begin
          meta_dest_d = {1'b0, start_q} + 9'(offs_q);
          meta_last_d = (rem_q == BW'(1));
          rd_ptr_d    = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
          offs_d      = offs_q + 1'b1;
          rem_d       = rem_q - 1'b1;
          if (rem_q == BW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (space) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      min_avail_q <= MIN_AVAIL_RST;
      burst_lim_q <= BURST_LIMIT_RST;
      start_q     <= '0;
      rem_q       <= '0;
      offs_q      <= '0;
      inflight_q  <= 1'b0;
      meta_dest_q <= '0;
      meta_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      min_avail_q <= min_avail_d;
      burst_lim_q <= burst_lim_d;
      start_q     <= start_d;
      rem_q       <= rem_d;
      offs_q      <= offs_d;
      inflight_q  <= inflight_d;
      meta_dest_q <= meta_dest_d;
      meta_last_q <= meta_last_d;
    end
  end

  brb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept & (in_data_i.command == CMD_WRITE)),
    .waddr_i(wr_ptr_q),
    .wdata_i(in_data_i.data_byte),
    .re_i   (issue),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    fifo_push = inflight_q | ((state_q == ST_EMPTY) & space);
    if (inflight_q) begin
      fifo_push_data.data_out   = ram_rdata;
      fifo_push_data.dest_index = meta_dest_q;
      fifo_push_data.no_data    = 1'b0;
      fifo_push_data.last       = meta_last_q;
    end else begin
      fifo_push_data.data_out   = 8'd0;
      fifo_push_data.dest_index = {1'b0, start_q};
      fifo_push_data.no_data    = 1'b1;
      fifo_push_data.last       = 1'b1;
    end
  end

  brb_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_data_i(fifo_push_data),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o),
    .count_o    (fifo_count)
  );

endmodule

`default_nettype wire

// ===== hdl/brb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/brb_out_fifo.sv =====
// two-entry output queue that decouples result beats from the downstream stall
// depends on brb_pkg
`timescale 1ns / 1ps
`default_nettype none

module brb_out_fifo
  import brb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire brb_out_t push_data_i,
  input  wire logic     pop_i,
  output logic          valid_o,
  output brb_out_t      data_o,
  output logic [1:0]    count_o
);

  brb_out_t   slot_q [2];
  logic       wr_sel_q, wr_sel_d;
  logic       rd_sel_q, rd_sel_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_sel_d = push_i ? ~wr_sel_q : wr_sel_q;
    rd_sel_d = pop_i ? ~rd_sel_q : rd_sel_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_sel_q <= 1'b0;
      rd_sel_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_sel_q <= wr_sel_d;
      rd_sel_q <= rd_sel_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_sel_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_sel_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== hdl/brb_checker.sv =====
// port-level checks for the byte ring buffer burst read core, bound to the top level
// depends on brb_pkg and byte_ring_buffer_burst_read_core
`timescale 1ns / 1ps
`default_nettype none

module brb_checker
  import brb_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire brb_in_t    in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire brb_out_t   out_data_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // no-data beat is a lone, zeroed, final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_data |-> out_data_o.last && out_data_o.data_out == 8'd0)
    else $error("no-data beat malformed");

  // block is busy in the cycle after a read beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.command == CMD_READ |=> in_stall_o)
    else $error("input not held off after read");

  // consecutive beats of one burst have consecutive destination indexes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last ##1 out_valid_o
      |-> out_data_o.dest_index == $past(out_data_o.dest_index) + 9'd1)
    else $error("burst destination index not consecutive");

endmodule

bind byte_ring_buffer_burst_read_core brb_checker u_brb_checker (.*);

`default_nettype wire
